// ----- rtl/tcbh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbh_pkg: shared types and constants for the three-choice bucket hash
// Field widths, mixer constants and the xor-shift helper.
// ----------------------------------------------------------------------------
package tcbh_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned CfgW  = 15;
  localparam int unsigned BktW  = 14;
  localparam int unsigned Lanes = 3;

  typedef logic [KeyW-1:0] word_t;

  // SplitMix64 finalizer constants; multipliers split in 32-bit halves
  localparam word_t       Gold   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [31:0] Mul1Lo = 32'h1ce4_e5b9;
  localparam logic [31:0] Mul1Hi = 32'hbf58_476d;
  localparam logic [31:0] Mul2Lo = 32'h1331_11eb;
  localparam logic [31:0] Mul2Hi = 32'h94d0_49bb;

  localparam int unsigned Shift1 = 30;
  localparam int unsigned Shift2 = 27;
  localparam int unsigned Shift3 = 31;

  localparam int unsigned MinCount = 3;
  localparam logic [CfgW-1:0] CfgReset = 15'd1024;

  function automatic word_t xs(word_t v, int unsigned s);
    return v ^ (v >> s);
  endfunction

endpackage

// ----- rtl/three_choice_bucket_hash.sv -----
`timescale 1ns / 1ps
// A key passes through 23 stages before its result is valid.
// Throughput: one key per cycle; each stage holds while the stage after it
// is full and stalled, so bubbles are squeezed out and input keeps flowing.
// Depth is set by the remainder chain: 16 stages of 4 restoring steps each.
// Reset clears all stage valid bits; bucket count resets to 1024 (clamped).
// ----------------------------------------------------------------------------
// three_choice_bucket_hash
// Hashes a 64-bit key three ways (SplitMix64 of key*3+i), reduces each modulo
// the bucket count and bumps later candidates until all three differ.
// ----------------------------------------------------------------------------
module three_choice_bucket_hash #(
  parameter int unsigned MAX_BUCKETS = 16384
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tcbh_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tcbh_pkg::KeyW-1:0] key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [tcbh_pkg::BktW-1:0] first_bucket_o,
  output logic [tcbh_pkg::BktW-1:0] second_bucket_o,
  output logic [tcbh_pkg::BktW-1:0] third_bucket_o
);

  localparam int unsigned CntW      = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned ModDigits = 4;
  localparam int unsigned ModStages = tcbh_pkg::KeyW / ModDigits;
  localparam int unsigned ModBase   = 6;
  localparam int unsigned NS        = ModBase + ModStages + 1;
  localparam int unsigned CntResetI =
    (32'(tcbh_pkg::CfgReset) > MAX_BUCKETS) ? MAX_BUCKETS : 32'(tcbh_pkg::CfgReset);

  // one restoring-remainder step per digit bit, MSB first
  function automatic logic [CntW-1:0] mod_digits(logic [CntW-1:0] r_in,
                                                 logic [ModDigits-1:0] dig,
                                                 logic [CntW-1:0] n);
    logic [CntW:0]   r2;
    logic [CntW-1:0] r;
    r = r_in;
    for (int s = ModDigits - 1; s >= 0; s--) begin
      r2 = {r, dig[s]};
      if (r2 >= {1'b0, n}) begin
        r2 = r2 - {1'b0, n};
      end
      r = r2[CntW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] c, logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = {1'b0, c} + 1'b1;
    return (s == {1'b0, n}) ? '0 : s[CntW-1:0];
  endfunction

  function automatic logic [tcbh_pkg::BktW-1:0] to_bkt(logic [CntW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[tcbh_pkg::BktW-1:0];
  endfunction

  // ---------------- bucket count register (stored clamped) ----------------
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     wr_val;

  assign wr_val = 32'(cfg_wdata_i);

  always_comb begin
    if (wr_val < tcbh_pkg::MinCount) begin
      cnt_d = CntW'(tcbh_pkg::MinCount);
    end else if (wr_val > MAX_BUCKETS) begin
      cnt_d = CntW'(MAX_BUCKETS);
    end else begin
      cnt_d = CntW'(wr_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(CntResetI);
    end else if (cfg_we_i) begin
      cnt_q <= cnt_d;
    end
  end

  // ---------------- stage valid / enable chain ----------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign v_in = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en[NS-1:0] & v_in) | (~en[NS-1:0] & v_q);
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // ---------------- per-lane hash and remainder ----------------
  tcbh_pkg::word_t key3;
  logic [CntW-1:0] rem_fin [tcbh_pkg::Lanes];

  assign key3 = key_i + {key_i[tcbh_pkg::KeyW-2:0], 1'b0};

  for (genvar l = 0; l < tcbh_pkg::Lanes; l++) begin : g_lane
    tcbh_pkg::word_t t_q, a_q, p_q, h_q;
    tcbh_pkg::word_t b, hf;
    logic [63:0]     ll1_q, ll2_q;
    logic [31:0]     lh1_q, hl1_q, lh2_q, hl2_q;
    logic [CntW-1:0] rem_q [ModStages];
    logic [CntW-1:0] rem_d [ModStages];
    tcbh_pkg::word_t dvd_q [ModStages];
    tcbh_pkg::word_t dvd_d [ModStages];

    assign b  = tcbh_pkg::xs(p_q, tcbh_pkg::Shift2);
    assign hf = tcbh_pkg::xs(h_q, tcbh_pkg::Shift3);

    // 64x64 low product = lo*lo + ((lo*hi + hi*lo) << 32)
    always_ff @(posedge clk_i) begin
      if (en[0]) begin
        t_q <= key3 + 64'(l);
      end
      if (en[1]) begin
        a_q <= tcbh_pkg::xs(t_q + tcbh_pkg::Gold, tcbh_pkg::Shift1);
      end
      if (en[2]) begin
        ll1_q <= a_q[31:0] * tcbh_pkg::Mul1Lo;
        lh1_q <= a_q[31:0] * tcbh_pkg::Mul1Hi;
        hl1_q <= a_q[63:32] * tcbh_pkg::Mul1Lo;
      end
      if (en[3]) begin
        p_q <= ll1_q + {lh1_q + hl1_q, 32'h0};
      end
      if (en[4]) begin
        ll2_q <= b[31:0] * tcbh_pkg::Mul2Lo;
        lh2_q <= b[31:0] * tcbh_pkg::Mul2Hi;
        hl2_q <= b[63:32] * tcbh_pkg::Mul2Lo;
      end
      if (en[5]) begin
        h_q <= ll2_q + {lh2_q + hl2_q, 32'h0};
      end
    end

    for (genvar j = 0; j < ModStages; j++) begin : g_mod
      if (j == 0) begin : g_first
        assign rem_d[j] = mod_digits('0, hf[tcbh_pkg::KeyW-1 -: ModDigits], cnt_q);
        assign dvd_d[j] = hf << ModDigits;
      end else begin : g_next
        assign rem_d[j] = mod_digits(rem_q[j-1],
                                     dvd_q[j-1][tcbh_pkg::KeyW-1 -: ModDigits], cnt_q);
        assign dvd_d[j] = dvd_q[j-1] << ModDigits;
      end

      always_ff @(posedge clk_i) begin
        if (en[ModBase+j]) begin
          rem_q[j] <= rem_d[j];
          dvd_q[j] <= dvd_d[j];
        end
      end
    end

    assign rem_fin[l] = rem_q[ModStages-1];
  end

  // ---------------- distinctness fix-up and output register ----------------
  logic [CntW-1:0] c1, c2a, c2b, c2;
  logic [tcbh_pkg::BktW-1:0] first_q, second_q, third_q;

  always_comb begin
    c1  = (rem_fin[1] == rem_fin[0]) ? bump(rem_fin[1], cnt_q) : rem_fin[1];
    c2a = rem_fin[2];
    // two bumps always suffice to clear two earlier candidates
    c2b = (c2a == rem_fin[0] || c2a == c1) ? bump(c2a, cnt_q) : c2a;
    c2  = (c2b == rem_fin[0] || c2b == c1) ? bump(c2b, cnt_q) : c2b;
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      first_q  <= to_bkt(rem_fin[0]);
      second_q <= to_bkt(c1);
      third_q  <= to_bkt(c2);
    end
  end

  assign first_bucket_o  = first_q;
  assign second_bucket_o = second_q;
  assign third_bucket_o  = third_q;

endmodule
